@@ sv/wph_pkg.sv @@
// Shared types, constants and codes of the wireless pairing handshake.
package wph_pkg;

    localparam int TIME_BITS = 32;
    localparam int MAC_BITS = 48;
    localparam int CFG_DATA_BITS = 48;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0] PAIR_PACKET_BYTES = 8'd9;

    localparam logic [63:0] TAG_DISCOVER = 64'h4A53505F44495343;
    localparam logic [63:0] TAG_CONFIRM = 64'h4A53505F434F4E46;
    localparam logic [MAC_BITS-1:0] MAC_ALL_ONES = {MAC_BITS{1'b1}};

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_PACKET = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_DISC = 2'd1;
    localparam logic [1:0] SEND_RESP = 2'd2;
    localparam logic [1:0] SEND_ACK = 2'd3;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_DISC = 2'd1;
    localparam logic [1:0] PHASE_WAIT = 2'd2;

    localparam logic [1:0] CFG_MANUAL_PEER = 2'd0;
    localparam logic [1:0] CFG_MANUAL_CHANNEL = 2'd1;
    localparam logic [1:0] CFG_RETRY_INTERVAL = 2'd2;
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd3;

    localparam logic [3:0] CHANNEL_DEFAULT = 4'd1;
    localparam logic [3:0] CHANNEL_MAX = 4'd14;

    localparam logic [15:0] RETRY_INTERVAL_RESET = 16'd200;
    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd5000;

    typedef struct packed {
        logic [1:0]           func;
        logic [TIME_BITS-1:0] now_ms;
        logic [MAC_BITS-1:0]  source_address;
        logic [7:0]           packet_length;
        logic [63:0]          tag_head;
        logic [7:0]           tag_tail;
        logic                 stored_valid;
        logic [MAC_BITS-1:0]  stored_address;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]          send_kind;
        logic [MAC_BITS-1:0] send_destination;
        logic                add_peer;
        logic                delete_peer_first;
        logic [MAC_BITS-1:0] peer_address;
        logic                save_peer;
        logic                channel_valid;
        logic [3:0]          channel_value;
        logic                forward_to_scan;
        logic                paired_now;
        logic [1:0]          phase;
    } rsp_word_t;

    typedef struct packed {
        logic [MAC_BITS-1:0] manual_peer_address;
        logic [3:0]          manual_channel_number;
        logic [15:0]         retry_interval_ms;
        logic [15:0]         ack_timeout_ms;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_TICK,
        OP_FORWARD,
        OP_DISC,
        OP_CONF
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [TIME_BITS-1:0] now_ms;
        logic [MAC_BITS-1:0]  address;
        logic                 stored_valid;
    } op_word_t;

endpackage

@@ sv/wph_front.sv @@
// Front end: decodes each input word into a short operation for the back end.
module wph_front (
    input  wph_pkg::cmd_word_t cmd,
    output wph_pkg::op_word_t  op_word
);

    wph_pkg::op_t op;
    logic         pair_length;

    assign pair_length = (cmd.packet_length == wph_pkg::PAIR_PACKET_BYTES);

    always_comb
    begin
        op = wph_pkg::OP_NONE;
        unique case (cmd.func)
            wph_pkg::FUNC_START:
            begin
                op = wph_pkg::OP_START;
            end
            wph_pkg::FUNC_TICK:
            begin
                op = wph_pkg::OP_TICK;
            end
            wph_pkg::FUNC_PACKET:
            begin
                if (!pair_length)
                begin
                    op = wph_pkg::OP_FORWARD;
                end
                else if (cmd.tag_tail == 8'd0 && cmd.tag_head == wph_pkg::TAG_DISCOVER)
                begin
                    op = wph_pkg::OP_DISC;
                end
                else if (cmd.tag_tail == 8'd0 && cmd.tag_head == wph_pkg::TAG_CONFIRM)
                begin
                    op = wph_pkg::OP_CONF;
                end
                else
                begin
                    op = wph_pkg::OP_NONE;
                end
            end
            wph_pkg::FUNC_UNUSED:
            begin
                op = wph_pkg::OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        op_word.op = op;
        op_word.now_ms = cmd.now_ms;
        op_word.stored_valid = cmd.stored_valid;
        op_word.address = (cmd.func == wph_pkg::FUNC_START) ? cmd.stored_address
                                                            : cmd.source_address;
    end

endmodule

@@ sv/wph_queue.sv @@
// Short queue of decoded operations between the front and back ends.
module wph_queue #(
    parameter int DEPTH = wph_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_stall,
    input  wph_pkg::op_word_t push_word,
    output logic              pop_valid,
    input  logic              pop_stall,
    output wph_pkg::op_word_t pop_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wph_pkg::op_word_t slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_stall = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_word = slot_reg[rd_ptr_reg];
    assign push = push_valid && !push_stall;
    assign pop = pop_valid && !pop_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ sv/wph_back.sv @@
// Back end: holds the pairing state, carries out operations and registers results.
module wph_back (
    input  logic              clk,
    input  logic              rst_n,
    input  wph_pkg::cfg_t     cfg,
    input  logic              op_valid,
    output logic              op_stall,
    input  wph_pkg::op_word_t op_word,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output wph_pkg::rsp_word_t rsp_word
);

    logic                          paired_reg, paired_next;
    logic                          ack_pending_reg, ack_pending_next;
    logic [1:0]                    phase_reg, phase_next;
    logic [wph_pkg::MAC_BITS-1:0]  link_peer_reg, link_peer_next;
    logic [wph_pkg::MAC_BITS-1:0]  pending_mac_reg, pending_mac_next;
    logic [wph_pkg::TIME_BITS-1:0] last_send_reg, last_send_next;
    logic [wph_pkg::TIME_BITS-1:0] phase_start_reg, phase_start_next;
    logic                          valid_reg;
    wph_pkg::rsp_word_t            rsp_reg, rsp_next;
    logic                          take;
    logic                          complete;
    logic [3:0]                    channel;
    logic [wph_pkg::TIME_BITS-1:0] since_send;
    logic [wph_pkg::TIME_BITS-1:0] since_phase;

    assign take = op_valid && (!valid_reg || !rsp_stall);
    assign op_stall = !take;
    assign rsp_valid = valid_reg;
    assign rsp_word = rsp_reg;

    assign since_send = op_word.now_ms - last_send_reg;
    assign since_phase = op_word.now_ms - phase_start_reg;
    assign channel = (cfg.manual_channel_number > wph_pkg::CHANNEL_MAX) ? wph_pkg::CHANNEL_MAX
                                                                       : cfg.manual_channel_number;

    always_comb
    begin
        rsp_next = '0;
        complete = 1'b0;
        paired_next = paired_reg;
        ack_pending_next = ack_pending_reg;
        phase_next = phase_reg;
        link_peer_next = link_peer_reg;
        pending_mac_next = pending_mac_reg;
        last_send_next = last_send_reg;
        phase_start_next = phase_start_reg;
        unique case (op_word.op)
            wph_pkg::OP_START:
            begin
                rsp_next.channel_valid = 1'b1;
                rsp_next.channel_value = wph_pkg::CHANNEL_DEFAULT;
                if (cfg.manual_peer_address != '0)
                begin
                    link_peer_next = cfg.manual_peer_address;
                    rsp_next.save_peer = 1'b1;
                    rsp_next.peer_address = cfg.manual_peer_address;
                    rsp_next.add_peer = (cfg.manual_peer_address != wph_pkg::MAC_ALL_ONES);
                    paired_next = 1'b1;
                    phase_next = wph_pkg::PHASE_IDLE;
                    complete = 1'b1;
                end
                else if (op_word.stored_valid)
                begin
                    link_peer_next = op_word.address;
                    rsp_next.add_peer = 1'b1;
                    rsp_next.peer_address = op_word.address;
                    paired_next = 1'b1;
                    phase_next = wph_pkg::PHASE_IDLE;
                    complete = 1'b1;
                end
                else
                begin
                    phase_next = wph_pkg::PHASE_DISC;
                    last_send_next = '0;
                end
            end
            wph_pkg::OP_TICK:
            begin
                if (!paired_reg)
                begin
                    if (ack_pending_reg)
                    begin
                        rsp_next.send_kind = wph_pkg::SEND_ACK;
                        rsp_next.send_destination = pending_mac_reg;
                        ack_pending_next = 1'b0;
                        rsp_next.add_peer = 1'b1;
                        rsp_next.save_peer = 1'b1;
                        rsp_next.peer_address = link_peer_reg;
                        paired_next = 1'b1;
                        phase_next = wph_pkg::PHASE_IDLE;
                        complete = 1'b1;
                    end
                    else if (phase_reg == wph_pkg::PHASE_DISC)
                    begin
                        if (since_send >= wph_pkg::TIME_BITS'(cfg.retry_interval_ms))
                        begin
                            rsp_next.send_kind = wph_pkg::SEND_DISC;
                            rsp_next.send_destination = wph_pkg::MAC_ALL_ONES;
                            last_send_next = op_word.now_ms;
                        end
                    end
                    else if (phase_reg == wph_pkg::PHASE_WAIT)
                    begin
                        if (since_phase >= wph_pkg::TIME_BITS'(cfg.ack_timeout_ms))
                        begin
                            phase_next = wph_pkg::PHASE_DISC;
                            link_peer_next = '0;
                        end
                    end
                end
            end
            wph_pkg::OP_FORWARD:
            begin
                rsp_next.forward_to_scan = 1'b1;
            end
            wph_pkg::OP_DISC:
            begin
                if (!paired_reg && phase_reg == wph_pkg::PHASE_DISC)
                begin
                    link_peer_next = op_word.address;
                    rsp_next.add_peer = 1'b1;
                    rsp_next.peer_address = op_word.address;
                    rsp_next.send_kind = wph_pkg::SEND_RESP;
                    rsp_next.send_destination = op_word.address;
                    phase_next = wph_pkg::PHASE_WAIT;
                    phase_start_next = op_word.now_ms;
                    last_send_next = '0;
                end
            end
            wph_pkg::OP_CONF:
            begin
                if (!paired_reg && phase_reg == wph_pkg::PHASE_WAIT)
                begin
                    ack_pending_next = 1'b1;
                    pending_mac_next = link_peer_reg;
                end
            end
            wph_pkg::OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase

        // A manual channel moves the freshly paired peer onto that channel.
        if (complete && channel != 4'd0)
        begin
            rsp_next.channel_valid = 1'b1;
            rsp_next.channel_value = channel;
            if (link_peer_next != '0 && link_peer_next != wph_pkg::MAC_ALL_ONES)
            begin
                rsp_next.delete_peer_first = 1'b1;
                rsp_next.add_peer = 1'b1;
                rsp_next.peer_address = link_peer_next;
            end
        end

        rsp_next.paired_now = paired_next;
        rsp_next.phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paired_reg <= 1'b0;
            ack_pending_reg <= 1'b0;
            phase_reg <= wph_pkg::PHASE_IDLE;
            link_peer_reg <= '0;
            pending_mac_reg <= '0;
            last_send_reg <= '0;
            phase_start_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                paired_reg <= paired_next;
                ack_pending_reg <= ack_pending_next;
                phase_reg <= phase_next;
                link_peer_reg <= link_peer_next;
                pending_mac_reg <= pending_mac_next;
                last_send_reg <= last_send_next;
                phase_start_reg <= phase_start_next;
                valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

@@ sv/wireless_pairing_handshake.sv @@
// Top level of the wireless pairing handshake: configuration registers and the three stages.
//
//   port group          | direction | handshake           | word
//   cmd_*               | in        | cmd_valid/cmd_stall | cmd_word (start, tick or packet)
//   rsp_*               | out       | rsp_valid/rsp_stall | rsp_word (one result per command)
//   cfg_*               | in        | cfg_write           | cfg_index, cfg_data
//
// One command word is taken every cycle while the operation queue is not full. The edge that
// takes it writes it into the operation queue; the state unit then pops it and loads its
// result into its result register, from which the result can be taken.
// Reset clears the pairing state and loads the register defaults; there is no clearing pass.
// A stalled result holds in the result register while the queue keeps taking commands
// until it is full.
module wireless_pairing_handshake #(
    parameter int QUEUE_DEPTH = wph_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  wph_pkg::cmd_word_t                cmd_word,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output wph_pkg::rsp_word_t                rsp_word,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [wph_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    wph_pkg::cfg_t     cfg_reg;
    wph_pkg::op_word_t front_word;
    wph_pkg::op_word_t queue_word;
    logic              queue_valid;
    logic              back_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.manual_peer_address <= '0;
            cfg_reg.manual_channel_number <= '0;
            cfg_reg.retry_interval_ms <= wph_pkg::RETRY_INTERVAL_RESET;
            cfg_reg.ack_timeout_ms <= wph_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wph_pkg::CFG_MANUAL_PEER:
                begin
                    cfg_reg.manual_peer_address <= cfg_data[wph_pkg::MAC_BITS-1:0];
                end
                wph_pkg::CFG_MANUAL_CHANNEL:
                begin
                    cfg_reg.manual_channel_number <= cfg_data[3:0];
                end
                wph_pkg::CFG_RETRY_INTERVAL:
                begin
                    cfg_reg.retry_interval_ms <= cfg_data[15:0];
                end
                wph_pkg::CFG_ACK_TIMEOUT:
                begin
                    cfg_reg.ack_timeout_ms <= cfg_data[15:0];
                end
            endcase
        end
    end

    wph_front u_front (
        .cmd     (cmd_word),
        .op_word (front_word)
    );

    wph_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_stall (cmd_stall),
        .push_word  (front_word),
        .pop_valid  (queue_valid),
        .pop_stall  (back_stall),
        .pop_word   (queue_word)
    );

    wph_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .op_valid  (queue_valid),
        .op_stall  (back_stall),
        .op_word   (queue_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule
